// File: rtl/distinct_set_min_max_span_defines.svh
// Assertion macros for the distinct value set block.
`ifndef DISTINCT_SET_MIN_MAX_SPAN_DEFINES_SVH
`define DISTINCT_SET_MIN_MAX_SPAN_DEFINES_SVH

`ifndef SYNTH
`define DSMMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DSMMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DSMMS_ASSERT(lbl, prop, msg)
`define DSMMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/dsmms_pkg.sv
// Types and constants shared by the distinct value set block.
package dsmms_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W = 32;
  localparam int unsigned GAP_W = KEY_W + 1;
  localparam logic [KEY_W-1:0] KEY_BIAS = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_e;

  typedef struct packed {
    logic             cmp_en;
    logic             shift_en;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    logic             lt;
    logic             eq;
    logic             lside;
    logic             rside;
    logic [KEY_W-1:0] lgap;
    logic [KEY_W-1:0] rgap;
  } cell_stat_t;

endpackage

// File: rtl/distinct_set_min_max_span.sv
// Top level of the distinct value set with shortest and longest span.
// Keeps up to DEPTH distinct signed values in a sorted chain of cells and
// reports, for every accepted value, the insertion status, the count and the
// two spans. In the cycle of its transfer every cell compares its key with the
// new value; in the update state the chain shifts to insert it while the
// gaps to its two new neighbours update the shortest span. The update waits
// while the previous result is still held in the output register, and no new
// value is taken until it is done. No clearing pass is needed after reset.
`include "distinct_set_min_max_span_defines.svh"

module distinct_set_min_max_span import dsmms_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [6:0]  stored_count_o,
  output logic        spans_valid_o,
  output logic [31:0] shortest_span_o,
  output logic [31:0] longest_span_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [GAP_W-1:0] gap_q, gap_d;
  logic [KEY_W-1:0] min_q, min_d, max_q, max_d, key_q;
  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic [6:0]       cnt_out_q, cnt_out_d;
  logic             sv_q, sv_d;
  logic [31:0]      short_q, short_d, long_q, long_d;

  logic             in_fire, upd_go, ins, dup, full, has_left, has_right;
  logic [KEY_W-1:0] lgap, rgap;
  logic [DEPTH-1:0] eq_vec;
  cell_ctrl_t       ctrl;
  logic [KEY_W-1:0] cell_key [DEPTH];
  cell_stat_t       cell_stat [DEPTH];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign upd_go     = (state_q == S_UPD) && (!out_valid_q || out_ready_i);

  assign ctrl.cmp_en   = in_fire;
  assign ctrl.shift_en = upd_go && ins;
  assign ctrl.key      = in_fire ? (value_i ^ KEY_BIAS) : key_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] left_key;
    logic             left_lt, right_lt;
    if (i == 0) begin : g_first
      assign left_key = ctrl.key;
      assign left_lt  = 1'b1;
    end else begin : g_rest
      assign left_key = cell_key[i-1];
      assign left_lt  = cell_stat[i-1].lt;
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_lt = 1'b0;
    end else begin : g_inner
      assign right_lt = cell_stat[i+1].lt;
    end
    dsmms_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .occ_i      (CNT_W'(i) < count_q),
      .left_key_i (left_key),
      .left_lt_i  (left_lt),
      .right_lt_i (right_lt),
      .key_o      (cell_key[i]),
      .stat_o     (cell_stat[i])
    );
    assign eq_vec[i] = cell_stat[i].eq;
  end

  always_comb begin
    lgap      = '0;
    rgap      = '0;
    has_left  = 1'b0;
    has_right = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      lgap      = lgap | (cell_stat[i].lside ? cell_stat[i].lgap : '0);
      rgap      = rgap | (cell_stat[i].rside ? cell_stat[i].rgap : '0);
      has_left  = has_left | cell_stat[i].lside;
      has_right = has_right | cell_stat[i].rside;
    end
  end

  assign dup  = |eq_vec;
  assign full = (count_q == CNT_W'(DEPTH));
  assign ins  = !dup && !full;

  always_comb begin
    logic [GAP_W-1:0] g;
    g         = gap_q;
    count_d   = count_q;
    min_d     = min_q;
    max_d     = max_q;
    status_d  = dup ? ST_DUPLICATE : (full ? ST_FULL : ST_INSERTED);
    if (ins) begin
      if (has_left && ({1'b0, lgap} < g)) begin
        g = {1'b0, lgap};
      end
      if (has_right && ({1'b0, rgap} < g)) begin
        g = {1'b0, rgap};
      end
      count_d = count_q + CNT_W'(1);
      if (!has_left) begin
        min_d = key_q;
      end
      if (!has_right) begin
        max_d = key_q;
      end
    end
    gap_d     = g;
    cnt_out_d = 7'(count_d);
    sv_d      = (count_d >= CNT_W'(2));
    short_d   = sv_d ? g[KEY_W-1:0] : '0;
    long_d    = sv_d ? (max_d - min_d) : '0;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_go) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      gap_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (upd_go) begin
        count_q <= count_d;
        gap_q   <= gap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q <= value_i ^ KEY_BIAS;
    end
    if (upd_go) begin
      min_q     <= min_d;
      max_q     <= max_d;
      status_q  <= status_d;
      cnt_out_q <= cnt_out_d;
      sv_q      <= sv_d;
      short_q   <= short_d;
      long_q    <= long_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign stored_count_o  = cnt_out_q;
  assign spans_valid_o   = sv_q;
  assign shortest_span_o = short_q;
  assign longest_span_o  = long_q;

  `DSMMS_ASSERT(a_one_match, (state_q == S_UPD) |-> $onehot0(eq_vec), "several cells match")
  `DSMMS_ASSERT(a_fire_to_upd, in_fire |=> (state_q == S_UPD), "transfer did not start an update")
  `DSMMS_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH), "count beyond depth")

endmodule

// File: rtl/dsmms_cell.sv
// One cell of the sorted chain: holds a key, compares it and shifts it onwards.
module dsmms_cell import dsmms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             occ_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic             left_lt_i,
  input  logic             right_lt_i,
  output logic [KEY_W-1:0] key_o,
  output cell_stat_t       stat_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic             lt_q, lt_d;
  logic             eq_q, eq_d;
  logic             occ_q, occ_d;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.shift_en && !lt_q) begin
      key_d = left_lt_i ? ctrl_i.key : left_key_i;
    end
  end

  always_comb begin
    lt_d  = lt_q;
    eq_d  = eq_q;
    occ_d = occ_q;
    if (ctrl_i.cmp_en) begin
      lt_d  = occ_i && (key_q < ctrl_i.key);
      eq_d  = occ_i && (key_q == ctrl_i.key);
      occ_d = occ_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      eq_q  <= 1'b0;
      occ_q <= 1'b0;
    end else begin
      lt_q  <= lt_d;
      eq_q  <= eq_d;
      occ_q <= occ_d;
    end
  end

  assign key_o        = key_q;
  assign stat_o.lt    = lt_q;
  assign stat_o.eq    = eq_q;
  assign stat_o.lside = lt_q && !right_lt_i;
  assign stat_o.rside = occ_q && !lt_q && left_lt_i;
  assign stat_o.lgap  = ctrl_i.key - key_q;
  assign stat_o.rgap  = key_q - ctrl_i.key;

endmodule
